@@ hw/rtl/b64_pkg.sv @@
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, codes and character mapping functions for the Base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

	localparam int unsigned MaxRes   = 6;
	localparam int unsigned ResCntW  = 3;

	localparam logic [7:0] ChPad     = 8'h3D;  // '='
	localparam logic [7:0] ChPlus    = 8'h2B;  // '+'
	localparam logic [7:0] ChSlash   = 8'h2F;  // '/'
	localparam logic [7:0] SxInvalid = 8'hFF;

	// one result item
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       no_data;
	} res_t;

	// stream state carried between items
	typedef struct packed {
		logic [23:0] gbytes;
		logic [1:0]  gcnt;
		logic [23:0] held;
		logic        hvld;
		logic [7:0]  prev;
	} st_t;

	localparam st_t StClear = '{gbytes: 24'h0, gcnt: 2'd0, held: 24'h0, hvld: 1'b0,
		prev: 8'h0};

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] c;
		begin
			if (s < 6'd26) begin
				c = 8'h41 + {2'b00, s};
			end else if (s < 6'd52) begin
				c = 8'h61 + {2'b00, s - 6'd26};
			end else if (s < 6'd62) begin
				c = 8'h30 + {2'b00, s - 6'd52};
			end else if (s == 6'd62) begin
				c = ChPlus;
			end else begin
				c = ChSlash;
			end
			return c;
		end
	endfunction

	function automatic logic [7:0] char_sextet(input logic [7:0] ch);
		logic [6:0] c;
		logic [7:0] v;
		begin
			c = ch[6:0];
			if (c >= 7'h41 && c <= 7'h5A) begin
				v = {1'b0, c - 7'h41};
			end else if (c >= 7'h61 && c <= 7'h7A) begin
				v = {1'b0, c - 7'h61} + 8'd26;
			end else if (c >= 7'h30 && c <= 7'h39) begin
				v = {1'b0, c - 7'h30} + 8'd52;
			end else if (c == ChPlus[6:0]) begin
				v = 8'd62;
			end else if (c == ChSlash[6:0]) begin
				v = 8'd63;
			end else if (c == ChPad[6:0]) begin
				v = 8'd0;
			end else begin
				v = SxInvalid;
			end
			return v;
		end
	endfunction

endpackage

@@ hw/rtl/base64_stream_codec_unit.sv @@
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Base64 encoder/decoder on a byte stream, mode set by a one-bit register.
// ----------------------------------------------------------------------------
//  channel    | dir | tdata          | tlast    | tuser
//  s_axis     | in  | in_byte [7:0]  | in_last  | -
//  m_axis     | out | out_byte [7:0] | out_last | no_data [0]
//  decode_mode| in  | write enable + 1-bit data, no read-back
//
//  An item is taken into the input register every cycle the step logic can
//  pass the previous one on; results leave the buffer one per cycle unless m_axis stalls.
//  An item producing k results occupies the result buffer until all k have left;
//  encode turns 3 bytes into 4 characters, decode takes one character a cycle
//  while the buffer can take its results, and a closing character yields up to six.
//  Results pass through the input register and the result buffer before m_axis.
//  Reset clears mode (encode), stream state and both handshake stages.
//  Stalls on m_axis back up through the buffer into s_axis_tready.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       decode_mode_we,
	input  logic       decode_mode_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic       m_axis_tlast,   // out_last
	output logic [0:0] m_axis_tuser    // no_data
);

	logic               mode_q;
	st_t                st_q;
	st_t                st_nxt;
	logic               vld_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	res_t               res [MaxRes];
	logic [ResCntW-1:0] res_cnt;
	logic               can_load;
	logic               adv;
	logic               load;

	// a request with no results may pass while the buffer still drains
	assign adv           = vld_s1 && (can_load || res_cnt == '0);
	assign load          = adv && (res_cnt != '0);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			st_q   <= StClear;
		end else if (decode_mode_we) begin
			mode_q <= decode_mode_wdata;
			st_q   <= StClear;
		end else if (adv) begin
			st_q   <= st_nxt;
		end
	end

	b64_core u_core (
		.decode_mode (mode_q),
		.in_byte     (byte_s1),
		.in_last     (last_s1),
		.st          (st_q),
		.st_nxt      (st_nxt),
		.res         (res),
		.res_cnt     (res_cnt)
	);

	b64_obuf u_obuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.load_res      (res),
		.load_cnt      (res_cnt),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_axis_tvalid || (m_axis_tready && $past(1'b1) && can_load)))
		else $error("result batch loaded over undelivered results");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		decode_mode_we |=> (st_q.gcnt == 2'd0 && !st_q.hvld))
		else $error("mode write did not clear stream state");

	a_nodata_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == 8'h0))
		else $error("no_data result malformed");

	a_encode_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !mode_q) |-> (res_cnt == ResCntW'(4) && !res[0].no_data))
		else $error("encode batch malformed");

endmodule

@@ hw/rtl/b64_core.sv @@
// ----------------------------------------------------------------------------
// b64_core
// Single-pass step logic: one registered item plus stream state in, next
// state and up to six result items out.
// ----------------------------------------------------------------------------
module b64_core import b64_pkg::*; (
	input  logic                 decode_mode,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  st_t                  st,
	output st_t                  st_nxt,
	output res_t                 res [MaxRes],
	output logic [ResCntW-1:0]   res_cnt
);

	always_comb begin
		logic [23:0] gb;
		logic [1:0]  gc_inc;
		logic        has2;
		logic        has3;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  v;
		logic        flush;
		logic        tr1;
		logic        tr2;
		logic [1:0]  nkeep;
		logic [ResCntW-1:0] base;
		logic [7:0]  k0;
		logic [7:0]  k1;
		logic [7:0]  k2;

		st_nxt  = st;
		res_cnt = '0;
		for (int i = 0; i < MaxRes; i++) begin
			res[i] = '{data: 8'h0, last: 1'b0, no_data: 1'b0};
		end
		gb = st.gbytes;
		gc_inc = st.gcnt + 2'd1;
		has2 = 1'b0; has3 = 1'b0;
		b0 = st.gbytes[23:16]; b1 = st.gbytes[15:8]; b2 = st.gbytes[7:0];
		v = char_sextet(in_byte);
		flush = 1'b0; tr1 = 1'b0; tr2 = 1'b0; nkeep = 2'd3; base = '0;
		k0 = 8'h0; k1 = 8'h0; k2 = 8'h0;

		if (!decode_mode) begin
			case (st.gcnt)
				2'd0:    gb = st.gbytes | {in_byte, 16'h0};
				2'd1:    gb = st.gbytes | {8'h0, in_byte, 8'h0};
				default: gb = st.gbytes | {16'h0, in_byte};
			endcase
			if (st.gcnt == 2'd2 || in_last) begin
				has2 = (st.gcnt != 2'd0);
				has3 = (st.gcnt == 2'd2);
				res[0].data = sextet_char(gb[23:18]);
				res[1].data = sextet_char({gb[17:16], has2 ? gb[15:12] : 4'h0});
				res[2].data = has2 ? sextet_char({gb[11:8], has3 ? gb[7:6] : 2'b00}) : ChPad;
				res[3].data = has3 ? sextet_char(gb[5:0]) : ChPad;
				res[3].last = in_last;
				res_cnt = ResCntW'(4);
				st_nxt.gbytes = '0;
				st_nxt.gcnt = '0;
				if (in_last) begin
					st_nxt = StClear;
				end
			end else begin
				st_nxt.gbytes = gb;
				st_nxt.gcnt = gc_inc;
			end
		end else begin
			case (st.gcnt)
				2'd0: begin
					b0 = {v[5:0], 2'b00}; b1 = 8'h0; b2 = 8'h0;
				end
				2'd1: begin
					b0 = b0 + {6'h0, v[5:4]}; b1 = {v[3:0], 4'h0};
				end
				2'd2: begin
					b1 = b1 + {4'h0, v[5:2]}; b2 = {v[1:0], 6'h0};
				end
				default: begin
					b2 = b2 + v;
				end
			endcase
			st_nxt.gbytes = {b0, b1, b2};
			st_nxt.gcnt = gc_inc;
			if (gc_inc == 2'd0) begin
				flush = st.hvld;
				st_nxt.held = {b0, b1, b2};
				st_nxt.hvld = 1'b1;
				st_nxt.gbytes = '0;
			end
			if (flush) begin
				res[0].data = st.held[23:16];
				res[1].data = st.held[15:8];
				res[2].data = st.held[7:0];
				base = ResCntW'(3);
			end
			res_cnt = base;
			if (!in_last) begin
				st_nxt.prev = in_byte;
			end else begin
				if (st_nxt.hvld) begin
					k0 = st_nxt.held[23:16];
					k1 = st_nxt.held[15:8];
					k2 = st_nxt.held[7:0];
					// trailing pad trimming, at most two bytes
					tr1 = (in_byte == ChPad) && (k2 == 8'h0);
					tr2 = (st.prev == ChPad) && ((tr1 ? k1 : k2) == 8'h0);
					nkeep = 2'd3 - {1'b0, tr1} - {1'b0, tr2};
					if (flush) begin
						res[3].data = k0; res[4].data = k1; res[5].data = k2;
						res[3].last = (nkeep == 2'd1);
						res[4].last = (nkeep == 2'd2);
						res[5].last = (nkeep == 2'd3);
					end else begin
						res[0].data = k0; res[1].data = k1; res[2].data = k2;
						res[0].last = (nkeep == 2'd1);
						res[1].last = (nkeep == 2'd2);
						res[2].last = (nkeep == 2'd3);
					end
					res_cnt = base + {1'b0, nkeep};
				end else begin
					res[0] = '{data: 8'h0, last: 1'b1, no_data: 1'b1};
					res_cnt = ResCntW'(1);
				end
				st_nxt = StClear;
			end
		end
	end

endmodule

@@ hw/rtl/b64_obuf.sv @@
// ----------------------------------------------------------------------------
// b64_obuf
// Result buffer: loaded with a whole batch of results, drains one per
// request through a shift line.
// ----------------------------------------------------------------------------
module b64_obuf import b64_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  res_t               load_res [MaxRes],
	input  logic [ResCntW-1:0] load_cnt,
	output logic               can_load,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata,   // out_byte
	output logic               m_axis_tlast,   // out_last
	output logic [0:0]         m_axis_tuser    // no_data
);

	res_t               ent_q [MaxRes];
	logic [ResCntW-1:0] cnt_q;
	logic               take;

	assign m_axis_tvalid = (cnt_q != '0);
	assign take          = m_axis_tvalid && m_axis_tready;
	assign can_load      = (cnt_q == '0) || (cnt_q == ResCntW'(1) && m_axis_tready);
	assign m_axis_tdata  = ent_q[0].data;
	assign m_axis_tlast  = ent_q[0].last;
	assign m_axis_tuser  = ent_q[0].no_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - ResCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_res;
		end else if (take) begin
			for (int i = 0; i < MaxRes - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

endmodule
